// ===== sv/plgi_pkg.sv =====
// ----------------------------------------------------------------------------
// plgi_pkg: shared definitions for the positional list get/insert block
// Sizes of the element store and count, request codes and sequencer states.
// ----------------------------------------------------------------------------
package plgi_pkg;

    // Store geometry
    localparam int CAPACITY = 64;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Transaction field widths
    localparam int POS_W    = 16;
    localparam int DATA_W   = 32;
    localparam int LEN_W    = 7;

    // Request codes
    localparam logic REQ_GET    = 1'b0;
    localparam logic REQ_INSERT = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GET_RD,
        ST_GET_DATA,
        ST_SHIFT,
        ST_INS_WR,
        ST_RESP
    } state_t;

endpackage

// ===== sv/positional_list_get_insert_top.sv =====
// ----------------------------------------------------------------------------
// positional_list_get_insert_top: ordered list with 1-based get and insert
// Keeps up to CAPACITY signed words in a single-port-write, one-read store.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req_type, position and insert_value and raise
//   start; the transaction is taken at a clock edge with start high and
//   busy low. busy stays high until the response has been shown.
//   Response channel: done is high for exactly one cycle with ok,
//   read_value and list_length valid; the receiver must take it then,
//   there is no back-pressure.
//   Sequence: a rejected request goes straight to the response; a get
//   reads the store and registers the data, then responds. An insert
//   shifts the elements from the end down to its place, writes the value
//   and responds; the shift loop moves one element per cycle through the
//   store's one read port and one write port (read of k-1 overlaps the
//   write of k+1). A new request is accepted the cycle after done.
//   Reset: the list is empty after reset; store contents are not cleared,
//   only the element count, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module positional_list_get_insert_top (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic                                    req_type,
    input  logic        [plgi_pkg::POS_W-1:0]       position,
    input  logic signed [plgi_pkg::DATA_W-1:0]      insert_value,
    output logic                                    done,
    output logic                                    ok,
    output logic signed [plgi_pkg::DATA_W-1:0]      read_value,
    output logic        [plgi_pkg::LEN_W-1:0]       list_length
);

    // Element store
    logic signed [plgi_pkg::DATA_W-1:0] mem [plgi_pkg::CAPACITY];
    logic signed [plgi_pkg::DATA_W-1:0] rdata_reg;
    logic        [plgi_pkg::ADDR_W-1:0] mem_raddr;
    logic        [plgi_pkg::ADDR_W-1:0] mem_waddr;
    logic signed [plgi_pkg::DATA_W-1:0] mem_wdata;
    logic                               mem_we;

    // Control state
    plgi_pkg::state_t                   state_reg, state_next;
    logic        [plgi_pkg::CNT_W-1:0]  count_reg, count_next;
    logic                               pend_reg, pend_next;

    // Working registers
    logic        [plgi_pkg::ADDR_W-1:0] idx_reg, idx_next;
    logic        [plgi_pkg::ADDR_W-1:0] tgt_reg, tgt_next;
    logic        [plgi_pkg::ADDR_W-1:0] wdst_reg, wdst_next;
    logic signed [plgi_pkg::DATA_W-1:0] value_reg, value_next;

    // Response registers
    logic                               ok_reg, ok_next;
    logic signed [plgi_pkg::DATA_W-1:0] read_value_reg, read_value_next;
    logic        [plgi_pkg::LEN_W-1:0]  length_reg, length_next;

    // Request checks
    logic        [plgi_pkg::POS_W-1:0]  pos_m1;
    logic        [plgi_pkg::POS_W-1:0]  count_ext;
    logic                               get_ok;
    logic                               ins_ok;

    assign pos_m1    = position - plgi_pkg::POS_W'(1);
    assign count_ext = plgi_pkg::POS_W'(count_reg);
    assign get_ok    = (position != '0) && (pos_m1 < count_ext);
    assign ins_ok    = (position != '0) && (pos_m1 <= count_ext)
                       && (count_reg != plgi_pkg::CNT_W'(plgi_pkg::CAPACITY));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            plgi_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (req_type == plgi_pkg::REQ_GET)
                        state_next = get_ok ? plgi_pkg::ST_GET_RD : plgi_pkg::ST_RESP;
                    else
                        state_next = ins_ok ? plgi_pkg::ST_SHIFT : plgi_pkg::ST_RESP;
                end
            end
            plgi_pkg::ST_GET_RD:   state_next = plgi_pkg::ST_GET_DATA;
            plgi_pkg::ST_GET_DATA: state_next = plgi_pkg::ST_RESP;
            plgi_pkg::ST_SHIFT:
            begin
                if (idx_reg == tgt_reg)
                    state_next = plgi_pkg::ST_INS_WR;
            end
            plgi_pkg::ST_INS_WR:   state_next = plgi_pkg::ST_RESP;
            plgi_pkg::ST_RESP:     state_next = plgi_pkg::ST_IDLE;
            default:               state_next = plgi_pkg::ST_IDLE;
        endcase
    end

    // Outputs and store port control
    always_comb
    begin
        busy      = 1'b1;
        done      = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = wdst_reg;
        mem_wdata = rdata_reg;
        mem_raddr = idx_reg;
        unique case (state_reg)
            plgi_pkg::ST_IDLE:     busy = 1'b0;
            plgi_pkg::ST_GET_RD:   mem_raddr = idx_reg;
            plgi_pkg::ST_GET_DATA: mem_raddr = idx_reg;
            plgi_pkg::ST_SHIFT:
            begin
                // read element k-1 while the previous one lands at its new place
                mem_raddr = idx_reg - plgi_pkg::ADDR_W'(1);
                mem_we    = pend_reg;
            end
            plgi_pkg::ST_INS_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = tgt_reg;
                mem_wdata = value_reg;
            end
            plgi_pkg::ST_RESP:     done = 1'b1;
            default:               busy = 1'b1;
        endcase
    end

    // Datapath next values
    always_comb
    begin
        count_next      = count_reg;
        pend_next       = pend_reg;
        idx_next        = idx_reg;
        tgt_next        = tgt_reg;
        wdst_next       = wdst_reg;
        value_next      = value_reg;
        ok_next         = ok_reg;
        read_value_next = read_value_reg;
        length_next     = length_reg;
        case (state_reg)
            plgi_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    // latch the transaction and prepare a reject response
                    idx_next        = (req_type == plgi_pkg::REQ_GET)
                                      ? plgi_pkg::ADDR_W'(pos_m1)
                                      : plgi_pkg::ADDR_W'(count_reg);
                    tgt_next        = plgi_pkg::ADDR_W'(pos_m1);
                    value_next      = insert_value;
                    pend_next       = 1'b0;
                    ok_next         = 1'b0;
                    read_value_next = '0;
                    length_next     = plgi_pkg::LEN_W'(count_reg);
                end
            end
            plgi_pkg::ST_GET_DATA:
            begin
                ok_next         = 1'b1;
                read_value_next = rdata_reg;
                length_next     = plgi_pkg::LEN_W'(count_reg);
            end
            plgi_pkg::ST_SHIFT:
            begin
                // advance the shift pointer toward the insert place
                if (idx_reg != tgt_reg)
                begin
                    pend_next = 1'b1;
                    wdst_next = idx_reg;
                    idx_next  = idx_reg - plgi_pkg::ADDR_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end
            plgi_pkg::ST_INS_WR:
            begin
                count_next      = count_reg + plgi_pkg::CNT_W'(1);
                ok_next         = 1'b1;
                read_value_next = '0;
                length_next     = plgi_pkg::LEN_W'(count_reg + plgi_pkg::CNT_W'(1));
            end
            default:
            begin
                pend_next = pend_reg;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= plgi_pkg::ST_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        tgt_reg        <= tgt_next;
        wdst_reg       <= wdst_next;
        value_reg      <= value_next;
        ok_reg         <= ok_next;
        read_value_reg <= read_value_next;
        length_reg     <= length_next;
    end

    // Store: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rdata_reg <= mem[mem_raddr];
    end

    assign ok          = ok_reg;
    assign read_value  = read_value_reg;
    assign list_length = length_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= plgi_pkg::CNT_W'(plgi_pkg::CAPACITY))
        else $error("element count above capacity");

    a_done_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("block still busy after response");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !ok) |-> (read_value == '0))
        else $error("rejected transaction returned data");

    a_shift_no_write_target: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == plgi_pkg::ST_SHIFT && pend_reg) |-> (wdst_reg != tgt_reg))
        else $error("shift overwrote the insert place");

endmodule
